>>> rtl/spct_pkg.sv
// Shared types and codes for the sorted parent count table
package spct_pkg;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] cc;
        logic [31:0] tc;
    } t_ent;

    typedef struct packed {
        logic       hit;
        logic       any;
        t_ent       ent;
        logic [7:0] pos;
    } t_leaf;

    typedef struct packed {
        logic        cmp;
        logic        op;
        logic [31:0] pid;
        logic [7:0]  ridx;
        logic        wr;
        logic        ins;
        t_ent        wval;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_UPD  = 2'd0,
        ST_INS  = 2'd1,
        ST_FULL = 2'd2,
        ST_READ = 2'd3
    } t_status;

    localparam logic OP_REG  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

>>> rtl/spct_cell.sv
// One table cell: holds an entry, compares locally, shifts from its lower neighbour
module spct_cell import spct_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int IDX     = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cmd                             i_cmd,
    input  logic [$clog2(ENTRIES+1)-1:0]     i_count,
    input  logic                             i_prev_lt,
    input  t_ent                             i_prev_ent,
    output logic                             o_lt,
    output t_ent                             o_ent,
    output t_leaf                            o_leaf
);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [7:0]    POS8   = 8'(IDX);
    localparam bit            RD_OK  = (IDX < 256);

    t_ent r_ent;
    logic r_sel;
    logic r_abv;

    logic occ;
    logic lt;
    logic eq;
    logic sel_ins;
    logic sel_rd;
    logic sel;

    assign occ     = MY_IDX < i_count;
    assign lt      = occ && (r_ent.id < i_cmd.pid);
    assign eq      = occ && (r_ent.id == i_cmd.pid);
    assign sel_ins = i_prev_lt && !lt;
    assign sel_rd  = occ && RD_OK && (POS8 == i_cmd.ridx);
    assign sel     = (i_cmd.op == OP_READ) ? sel_rd : sel_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_abv <= 1'b0;
        end else if (i_cmd.cmp) begin
            r_sel <= sel;
            r_abv <= !i_prev_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && r_sel) begin
            r_ent <= i_cmd.wval;
        end else if (i_cmd.ins && r_abv) begin
            r_ent <= i_prev_ent;
        end
    end

    assign o_lt          = lt;
    assign o_ent         = r_ent;
    assign o_leaf.hit    = sel && eq;
    assign o_leaf.any    = sel;
    assign o_leaf.ent    = sel ? r_ent : '0;
    assign o_leaf.pos    = sel ? POS8 : 8'd0;

endmodule

>>> rtl/spct_tree.sv
// Registered radix-4 OR tree gathering the selected cell's word
module spct_tree import spct_pkg::*; #(
    parameter int N    = 256,
    parameter int LVLS = 4
) (
    input  logic           i_clk,
    input  t_leaf [N-1:0]  i_leaf,
    output t_leaf          o_root
);
    function automatic int node_off(input int l);
        int s;
        s = 0;
        for (int k = 0; k < l; k++) begin
            s += 4 ** (LVLS - k);
        end
        return s;
    endfunction

    localparam int TN = node_off(LVLS + 1);

    t_leaf r_node [TN];

    for (genvar j = 0; j < 4 ** LVLS; j++) begin : g_leaf
        if (j < N) begin : g_used
            always_ff @(posedge i_clk) begin
                r_node[j] <= i_leaf[j];
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[j] <= '0;
            end
        end
    end

    for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
        localparam int OFF = node_off(l);
        localparam int PO  = node_off(l - 1);
        for (genvar j = 0; j < 4 ** (LVLS - l); j++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_node[OFF+j] <= t_leaf'(r_node[PO+4*j] | r_node[PO+4*j+1] |
                                         r_node[PO+4*j+2] | r_node[PO+4*j+3]);
            end
        end
    end

    assign o_root = r_node[TN-1];

endmodule

>>> rtl/sorted_parent_count_table.sv
// Sorted parent count table: chain of entry cells with a registered readout tree
// Results and o_done are registered from the commit state; the readout tree has LVLS = ceil(log4(ENTRIES)) levels.
// Each word steps through compare, the tree levels, commit and idle; a new word is accepted only in idle.
// o_busy is high from accept until the result is driven; the receiver cannot stall.
// Synchronous active-low reset empties the table at once; entry contents are not cleared.
module sorted_parent_count_table import spct_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [31:0] i_parent_id,
    input  logic        i_child_found,
    input  logic [31:0] i_child_cc,
    input  logic [31:0] i_child_tc,
    input  logic [7:0]  i_read_index,
    output logic        o_done,
    output logic [31:0] o_echo_cc,
    output logic [31:0] o_echo_tc,
    output logic [31:0] o_entry_id,
    output logic [31:0] o_entry_cc,
    output logic [31:0] o_entry_tc,
    output logic [7:0]  o_entry_pos,
    output logic [8:0]  o_table_count,
    output logic [1:0]  o_status
);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CWX  = (CW > 9) ? CW : 9;
    localparam int LVLS = ($clog2(ENTRIES) + 1) / 2;
    localparam int LW   = (LVLS > 1) ? $clog2(LVLS) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
    localparam logic [7:0]    FULL_POS = 8'(ENTRIES % 256);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_TREE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    t_state         r_state, n_state;
    logic [LW-1:0]  r_lvl, n_lvl;
    logic [CW-1:0]  r_count, n_count;
    logic           r_op;
    logic [31:0]    r_pid;
    logic           r_found;
    logic [31:0]    r_ccin;
    logic [31:0]    r_tcin;
    logic [7:0]     r_ridx;
    logic [31:0]    r_add;

    logic           r_done;
    logic [31:0]    r_echo_cc, r_echo_tc, r_entry_id, r_entry_cc, r_entry_tc;
    logic [7:0]     r_entry_pos;
    logic [8:0]     r_table_count;
    t_status        r_status;

    t_cmd               w_cmd;
    t_leaf [ENTRIES-1:0] w_leaf;
    logic               w_lt  [ENTRIES];
    t_ent               w_ent [ENTRIES];
    t_leaf              w_root;

    logic               accept;
    logic               full;
    logic               hit;
    logic               ins;
    logic [31:0]        new_cc;
    logic [31:0]        new_tc;
    logic [CWX-1:0]     cnt_x;

    assign accept = i_start && (r_state == S_IDLE);
    assign full   = r_count == FULL_CNT;
    assign hit    = (r_op == OP_REG) && w_root.hit;
    assign ins    = (r_op == OP_REG) && !w_root.hit && !full;
    assign new_cc = sat_add(w_root.ent.cc, 32'd1);
    assign new_tc = sat_add(w_root.ent.tc, r_add);

    always_comb begin
        w_cmd.cmp  = r_state == S_CMP;
        w_cmd.op   = r_op;
        w_cmd.pid  = r_pid;
        w_cmd.ridx = r_ridx;
        w_cmd.wr   = (r_state == S_DONE) && (hit || ins);
        w_cmd.ins  = (r_state == S_DONE) && ins;
        w_cmd.wval.id = r_pid;
        w_cmd.wval.cc = hit ? new_cc : 32'd1;
        w_cmd.wval.tc = hit ? new_tc : r_add;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_first
            spct_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_count    (r_count),
                .i_prev_lt  (1'b1),
                .i_prev_ent ('0),
                .o_lt       (w_lt[g]),
                .o_ent      (w_ent[g]),
                .o_leaf     (w_leaf[g])
            );
        end else begin : g_rest
            spct_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_count    (r_count),
                .i_prev_lt  (w_lt[g-1]),
                .i_prev_ent (w_ent[g-1]),
                .o_lt       (w_lt[g]),
                .o_ent      (w_ent[g]),
                .o_leaf     (w_leaf[g])
            );
        end
    end

    spct_tree #(.N(ENTRIES), .LVLS(LVLS)) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_TREE;
                n_lvl   = '0;
            end
            S_TREE: begin
                if (r_lvl == LW'(LVLS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                if (ins) begin
                    n_count = r_count + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_count <= n_count;
            r_done  <= r_state == S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_pid   <= i_parent_id;
            r_found <= i_child_found;
            r_ccin  <= i_child_cc;
            r_tcin  <= i_child_tc;
            r_ridx  <= i_read_index;
            r_add   <= (i_child_found && (i_child_tc != 32'd0)) ?
                       sat_add(i_child_tc, 32'd1) : 32'd1;
        end
    end

    assign cnt_x = CWX'(n_count);

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_table_count <= cnt_x[8:0];
            if (r_op == OP_READ) begin
                r_echo_cc   <= '0;
                r_echo_tc   <= '0;
                r_entry_id  <= w_root.ent.id;
                r_entry_cc  <= w_root.ent.cc;
                r_entry_tc  <= w_root.ent.tc;
                r_entry_pos <= r_ridx;
                r_status    <= ST_READ;
            end else begin
                r_echo_cc  <= r_found ? r_ccin : 32'd0;
                r_echo_tc  <= r_found ? r_tcin : 32'd0;
                r_entry_id <= r_pid;
                r_entry_pos <= w_root.any ? w_root.pos : FULL_POS;
                if (hit) begin
                    r_entry_cc <= new_cc;
                    r_entry_tc <= new_tc;
                    r_status   <= ST_UPD;
                end else if (ins) begin
                    r_entry_cc <= 32'd1;
                    r_entry_tc <= r_add;
                    r_status   <= ST_INS;
                end else begin
                    r_entry_cc <= '0;
                    r_entry_tc <= '0;
                    r_status   <= ST_FULL;
                end
            end
        end
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_done        = r_done;
    assign o_echo_cc     = r_echo_cc;
    assign o_echo_tc     = r_echo_tc;
    assign o_entry_id    = r_entry_id;
    assign o_entry_cc    = r_entry_cc;
    assign o_entry_tc    = r_entry_tc;
    assign o_entry_pos   = r_entry_pos;
    assign o_table_count = r_table_count;
    assign o_status      = r_status;

    a_done_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result strobe without a commit cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_INS)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("insert without count increment");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_count))
        else $error("entry count changed outside commit");

endmodule
